// ===== hdl/rotation_matrix_generator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Rotation matrix generator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_GENERATOR_CORE_DEFINES_SVH
`define ROTATION_MATRIX_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication
`define RMG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rmg_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix generator package
// Request and result types, CORDIC constants and rounding helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmg_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    // fold register, CORDIC steps, rounding register
    localparam int SC_LAT       = CORDIC_N + 2;

    localparam int ZW = 35;   // Q2.30 angle with headroom
    localparam int XW = 33;   // CORDIC x/y
    localparam int WW = 50;   // Q42 matrix accumulations

    localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;
    localparam logic signed [15:0]   ONE_Q14     = 16'sd16384;

    typedef enum logic [2:0] {
        OP_ROT_X = 3'd0,
        OP_ROT_Y = 3'd1,
        OP_ROT_Z = 3'd2,
        OP_RPY   = 3'd3,
        OP_QUAT  = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [15:0] axis_angle;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } req_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } mat_t;

    // opcode and quaternion riding alongside the CORDIC lanes
    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
    } side_t;

    typedef struct packed {
        logic               valid;
        side_t              side;
        logic signed [15:0] sr;
        logic signed [15:0] cr;
        logic signed [15:0] sp;
        logic signed [15:0] cp;
        logic signed [15:0] sy;
        logic signed [15:0] cy;
    } mat_in_t;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] t;
        case (i)
            0:       t = 35'sd843314857;
            1:       t = 35'sd497837830;
            2:       t = 35'sd263043837;
            3:       t = 35'sd133525159;
            4:       t = 35'sd67021687;
            5:       t = 35'sd33543515;
            6:       t = 35'sd16775850;
            7:       t = 35'sd8388438;
            8:       t = 35'sd4194283;
            9:       t = 35'sd2097149;
            default: t = ZW'(36'sd1 <<< (30 - i));
        endcase
        return t;
    endfunction

    // round half up by 16 bits and clamp to +-1.0 in Q1.14
    function automatic logic signed [15:0] round_q14(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] s;
        logic signed [16:0]   r;
        logic signed [15:0]   o;
        s = v + XW'(33'sd32768);
        r = 17'(s >>> 16);
        if (r > 17'sd16384)       o = ONE_Q14;
        else if (r < -17'sd16384) o = -ONE_Q14;
        else                      o = r[15:0];
        return o;
    endfunction

    // round half up by 28 bits and clamp to +-1.0 in Q1.14
    function automatic logic signed [15:0] round_q42(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] s;
        logic signed [21:0]   r;
        logic signed [15:0]   o;
        s = v + (WW'(50'sd1) <<< 27);
        r = 22'(s >>> 28);
        if (r > 22'sd16384)       o = ONE_Q14;
        else if (r < -22'sd16384) o = -ONE_Q14;
        else                      o = r[15:0];
        return o;
    endfunction

endpackage

// ===== hdl/rotation_matrix_generator_core.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix generator core
// Builds a Q1.14 3x3 rotation matrix from one axis angle, roll/pitch/yaw or
// a quaternion.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start high; busy never rises, so one
// request per clock is sustained. The matrix appears on result with done high
// for exactly one cycle, after the input register, the fold register, one
// register per CORDIC step, sine/cosine rounding and three matrix stages. The
// depth is set by the CORDIC step count.
// The receiver cannot hold results off, so sample result whenever done is
// high. Opcodes beyond the quaternion return the identity matrix.
`timescale 1ns / 1ps
`include "rotation_matrix_generator_core_defines.svh"

module rotation_matrix_generator_core
    import rmg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output mat_t result
);

    // input register: hold the request for the fold stage
    logic  v0_reg;
    req_t  req_reg;

    // side data delay line, matched to the sine/cosine latency
    side_t side_reg [0:SC_LAT-1];

    logic               lane0_angle_sel;
    logic signed [15:0] lane0_angle;
    logic               sc_valid [0:2];
    logic signed [15:0] sin_q [0:2];
    logic signed [15:0] cos_q [0:2];
    mat_in_t            mi;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        req_reg <= request;
    end

    // advance side data every cycle; nothing downstream can stall
    always_ff @(posedge clk)
    begin
        side_reg[0] <= '{opcode: req_reg.opcode, qw: req_reg.quat_w,
                         qx: req_reg.quat_x, qy: req_reg.quat_y, qz: req_reg.quat_z};
        for (int k = 1; k < SC_LAT; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // lane 0 serves the single-axis angle or roll
    assign lane0_angle_sel = (req_reg.opcode == OP_ROT_X) || (req_reg.opcode == OP_ROT_Y) ||
                             (req_reg.opcode == OP_ROT_Z);
    assign lane0_angle     = lane0_angle_sel ? req_reg.axis_angle : req_reg.roll_angle;

    rmg_sincos u_sc_roll
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .angle     (lane0_angle),
        .out_valid (sc_valid[0]),
        .sin_q     (sin_q[0]),
        .cos_q     (cos_q[0])
    );

    rmg_sincos u_sc_pitch
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .angle     (req_reg.pitch_angle),
        .out_valid (sc_valid[1]),
        .sin_q     (sin_q[1]),
        .cos_q     (cos_q[1])
    );

    rmg_sincos u_sc_yaw
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .angle     (req_reg.yaw_angle),
        .out_valid (sc_valid[2]),
        .sin_q     (sin_q[2]),
        .cos_q     (cos_q[2])
    );

    assign mi.valid = sc_valid[0];
    assign mi.side  = side_reg[SC_LAT-1];
    assign mi.sr    = sin_q[0];
    assign mi.cr    = cos_q[0];
    assign mi.sp    = sin_q[1];
    assign mi.cp    = cos_q[1];
    assign mi.sy    = sin_q[2];
    assign mi.cy    = cos_q[2];

    rmg_matrix u_matrix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mi        (mi),
        .out_valid (done),
        .mat       (result)
    );

    `RMG_ASSERT_IMP(a_lanes_aligned, sc_valid[0],
        sc_valid[1] && sc_valid[2], "sine/cosine lanes out of step")
    `RMG_ASSERT_IMP(a_lanes_idle, !sc_valid[0],
        !sc_valid[1] && !sc_valid[2], "sine/cosine lane valid without lane 0")
    `RMG_ASSERT_NXT(a_fold_to_cordic, v0_reg && busy == 1'b0,
        1'b1 && !busy, "busy rose with a request in flight")
    `RMG_ASSERT_IMP(a_result_range, done,
        (result.m00 <= ONE_Q14) && (result.m00 >= -ONE_Q14) &&
        (result.m11 <= ONE_Q14) && (result.m11 >= -ONE_Q14) &&
        (result.m22 <= ONE_Q14) && (result.m22 >= -ONE_Q14),
        "diagonal element outside saturation range")

endmodule

// ===== hdl/rmg_sincos.sv =====
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine/cosine
// Quadrant fold, one register per CORDIC step, then round to Q1.14.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmg_sincos
    import rmg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [15:0] angle,
    output logic               out_valid,
    output logic signed [15:0] sin_q,
    output logic signed [15:0] cos_q
);

    logic                 v_reg   [0:CORDIC_N];
    logic                 neg_reg [0:CORDIC_N];
    logic signed [XW-1:0] x_reg   [0:CORDIC_N];
    logic signed [XW-1:0] y_reg   [0:CORDIC_N];
    logic signed [ZW-1:0] z_reg   [0:CORDIC_N];

    logic signed [ZW-1:0] z_raw;
    logic signed [ZW-1:0] z_fold;
    logic                 neg_fold;

    logic                 ov_reg;
    logic signed [15:0]   s_reg;
    logic signed [15:0]   c_reg;

    assign z_raw = {{2{angle[15]}}, angle, 17'b0};

    always_comb
    begin
        if (z_raw > HALF_PI_Q30)
        begin
            z_fold   = z_raw - PI_Q30;
            neg_fold = 1'b1;
        end
        else if (z_raw < -HALF_PI_Q30)
        begin
            z_fold   = z_raw + PI_Q30;
            neg_fold = 1'b1;
        end
        else
        begin
            z_fold   = z_raw;
            neg_fold = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]   <= GAIN_Q30;
        y_reg[0]   <= '0;
        z_reg[0]   <= z_fold;
        neg_reg[0] <= neg_fold;
    end

    for (genvar k = 0; k < CORDIC_N; k++)
    begin : g_step
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        assign dx = y_reg[k] >>> k;
        assign dy = x_reg[k] >>> k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else
                v_reg[k+1] <= v_reg[k];
        end

        // zero residual steers positive
        always_ff @(posedge clk)
        begin
            neg_reg[k+1] <= neg_reg[k];
            if (!z_reg[k][ZW-1])
            begin
                x_reg[k+1] <= x_reg[k] - dx;
                y_reg[k+1] <= y_reg[k] + dy;
                z_reg[k+1] <= z_reg[k] - atan_q30(k);
            end
            else
            begin
                x_reg[k+1] <= x_reg[k] + dx;
                y_reg[k+1] <= y_reg[k] - dy;
                z_reg[k+1] <= z_reg[k] + atan_q30(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= v_reg[CORDIC_N];
    end

    always_ff @(posedge clk)
    begin
        if (neg_reg[CORDIC_N])
        begin
            c_reg <= round_q14(-x_reg[CORDIC_N]);
            s_reg <= round_q14(-y_reg[CORDIC_N]);
        end
        else
        begin
            c_reg <= round_q14(x_reg[CORDIC_N]);
            s_reg <= round_q14(y_reg[CORDIC_N]);
        end
    end

    assign out_valid = ov_reg;
    assign sin_q     = s_reg;
    assign cos_q     = c_reg;

endmodule

// ===== hdl/rmg_matrix.sv =====
// ----------------------------------------------------------------------------
// Matrix assembly
// Pairwise products, triple products and sums, then round and saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmg_matrix
    import rmg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  mat_in_t mi,
    output logic    out_valid,
    output mat_t    mat
);

    // stage 1: pairwise products
    logic               v1_reg;
    logic [2:0]         op1_reg;
    logic signed [15:0] s1_reg, c1_reg, cy1_reg, sy1_reg, sp1_reg;
    logic signed [31:0] pa_reg, pb_reg, cycp_reg, sycp_reg, cpsr_reg, cpcr_reg;
    logic signed [31:0] sycr_reg, sysr_reg, cycr_reg, cysr_reg;
    logic signed [31:0] aa_reg, bb_reg, cc_reg, dd_reg, bc_reg, ad_reg;
    logic signed [31:0] bd_reg, ac_reg, cd_reg, ab_reg;

    // stage 2: Q42 sums
    logic                 v2_reg;
    logic signed [WW-1:0] w_reg [0:8];
    logic signed [WW-1:0] w_next [0:8];

    logic v3_reg;
    mat_t m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= mi.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg  <= mi.side.opcode;
        s1_reg   <= mi.sr;
        c1_reg   <= mi.cr;
        cy1_reg  <= mi.cy;
        sy1_reg  <= mi.sy;
        sp1_reg  <= mi.sp;
        pa_reg   <= mi.sp * mi.sr;
        pb_reg   <= mi.sp * mi.cr;
        cycp_reg <= mi.cy * mi.cp;
        sycp_reg <= mi.sy * mi.cp;
        cpsr_reg <= mi.cp * mi.sr;
        cpcr_reg <= mi.cp * mi.cr;
        sycr_reg <= mi.sy * mi.cr;
        sysr_reg <= mi.sy * mi.sr;
        cycr_reg <= mi.cy * mi.cr;
        cysr_reg <= mi.cy * mi.sr;
        aa_reg   <= mi.side.qw * mi.side.qw;
        bb_reg   <= mi.side.qx * mi.side.qx;
        cc_reg   <= mi.side.qy * mi.side.qy;
        dd_reg   <= mi.side.qz * mi.side.qz;
        bc_reg   <= mi.side.qx * mi.side.qy;
        ad_reg   <= mi.side.qw * mi.side.qz;
        bd_reg   <= mi.side.qx * mi.side.qz;
        ac_reg   <= mi.side.qw * mi.side.qy;
        cd_reg   <= mi.side.qy * mi.side.qz;
        ab_reg   <= mi.side.qw * mi.side.qx;
    end

    // single-axis values sit at Q42 so the shared rounding returns them unchanged
    always_comb
    begin
        logic signed [WW-1:0] one42;
        logic signed [WW-1:0] s42;
        logic signed [WW-1:0] c42;
        logic signed [WW-1:0] q1;
        one42 = WW'(50'sd1) <<< 42;
        s42   = WW'(s1_reg) <<< 28;
        c42   = WW'(c1_reg) <<< 28;
        q1    = WW'(50'sd1) <<< 42;
        for (int k = 0; k < 9; k++)
            w_next[k] = (k % 4 == 0) ? one42 : '0;
        case (op1_reg)
            OP_ROT_X:
            begin
                w_next[4] = c42;
                w_next[5] = -s42;
                w_next[7] = s42;
                w_next[8] = c42;
            end
            OP_ROT_Y:
            begin
                w_next[0] = c42;
                w_next[2] = s42;
                w_next[6] = -s42;
                w_next[8] = c42;
            end
            OP_ROT_Z:
            begin
                w_next[0] = c42;
                w_next[1] = -s42;
                w_next[3] = s42;
                w_next[4] = c42;
            end
            OP_RPY:
            begin
                w_next[0] = WW'(cycp_reg) <<< 14;
                w_next[1] = cy1_reg * pa_reg - (WW'(sycr_reg) <<< 14);
                w_next[2] = cy1_reg * pb_reg + (WW'(sysr_reg) <<< 14);
                w_next[3] = WW'(sycp_reg) <<< 14;
                w_next[4] = sy1_reg * pa_reg + (WW'(cycr_reg) <<< 14);
                w_next[5] = sy1_reg * pb_reg - (WW'(cysr_reg) <<< 14);
                w_next[6] = -(WW'(sp1_reg) <<< 28);
                w_next[7] = WW'(cpsr_reg) <<< 14;
                w_next[8] = WW'(cpcr_reg) <<< 14;
            end
            OP_QUAT:
            begin
                w_next[0] = ((WW'(aa_reg) + WW'(bb_reg)) <<< 15) - q1;
                w_next[1] = (WW'(bc_reg) - WW'(ad_reg)) <<< 15;
                w_next[2] = (WW'(bd_reg) + WW'(ac_reg)) <<< 15;
                w_next[3] = (WW'(bc_reg) + WW'(ad_reg)) <<< 15;
                w_next[4] = ((WW'(aa_reg) + WW'(cc_reg)) <<< 15) - q1;
                w_next[5] = (WW'(cd_reg) - WW'(ab_reg)) <<< 15;
                w_next[6] = (WW'(bd_reg) - WW'(ac_reg)) <<< 15;
                w_next[7] = (WW'(cd_reg) + WW'(ab_reg)) <<< 15;
                w_next[8] = ((WW'(aa_reg) + WW'(dd_reg)) <<< 15) - q1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
            w_reg[k] <= w_next[k];
        m_reg.m00 <= round_q42(w_reg[0]);
        m_reg.m01 <= round_q42(w_reg[1]);
        m_reg.m02 <= round_q42(w_reg[2]);
        m_reg.m10 <= round_q42(w_reg[3]);
        m_reg.m11 <= round_q42(w_reg[4]);
        m_reg.m12 <= round_q42(w_reg[5]);
        m_reg.m20 <= round_q42(w_reg[6]);
        m_reg.m21 <= round_q42(w_reg[7]);
        m_reg.m22 <= round_q42(w_reg[8]);
    end

    assign out_valid = v3_reg;
    assign mat       = m_reg;

endmodule
